// ----- sv/almon_pkg.sv -----
package almon_pkg;

   localparam int THR_BITS            = 12;
   localparam int LEVEL_BITS          = 3;
   localparam int COUNT_BITS          = 8;
   localparam int OP_BITS             = 2;
   localparam int ALARM_BITS          = 3;
   localparam int CSR_INDEX_BITS      = 2;
   localparam int CSR_DATA_BITS       = 60;
   localparam int NUM_THR_ONE         = 5;
   localparam int NUM_THR_TWO         = 4;
   localparam int THR_ONE_BITS        = NUM_THR_ONE * THR_BITS;
   localparam int THR_TWO_BITS        = NUM_THR_TWO * THR_BITS;
   localparam int SAMPLE_BITS_DEFAULT = 12;

   localparam logic [COUNT_BITS-1:0] SETTLE_RESET = COUNT_BITS'(4);
   localparam logic [LEVEL_BITS-1:0] LEVEL_ONE_MAX = LEVEL_BITS'(NUM_THR_ONE);
   localparam logic [LEVEL_BITS-1:0] LEVEL_TWO_MAX = LEVEL_BITS'(NUM_THR_TWO);

   typedef enum logic [OP_BITS-1:0] {
      OP_LOOP_ONE = 2'd0,
      OP_LOOP_TWO = 2'd1,
      OP_EVALUATE = 2'd2
   } op_type;

   typedef enum logic [ALARM_BITS-1:0] {
      ALARM_NORMAL    = 3'd0,
      ALARM_TROUBLE   = 3'd1,
      ALARM_INTRUSION = 3'd2,
      ALARM_MASK      = 3'd3,
      ALARM_TAMPER    = 3'd4,
      ALARM_UNKNOWN   = 3'd5
   } alarm_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THR_ONE = 2'd0,
      CSR_THR_TWO = 2'd1,
      CSR_SETTLE  = 2'd2,
      CSR_ENABLE  = 2'd3
   } csr_type;

   typedef struct packed {
      logic [THR_ONE_BITS-1:0] thr_one;
      logic [THR_TWO_BITS-1:0] thr_two;
      logic [COUNT_BITS-1:0]   settle;
      logic                    enable;
   } cfg_type;

   typedef struct packed {
      logic change;
      logic value;
   } en_event_type;

   typedef struct packed {
      logic                  fire;
      logic [OP_BITS-1:0]    op;
      logic [LEVEL_BITS-1:0] level_one_new;
      logic [LEVEL_BITS-1:0] level_two_new;
   } cmd_type;

   typedef struct packed {
      alarm_type             alarm;
      logic [LEVEL_BITS-1:0] level_one;
      logic [LEVEL_BITS-1:0] level_two;
      logic                  settled;
   } status_type;

   function automatic logic [COUNT_BITS-1:0] debounce_count(
      input logic [LEVEL_BITS-1:0] level,
      input logic [LEVEL_BITS-1:0] fresh,
      input logic [COUNT_BITS-1:0] count,
      input logic [COUNT_BITS-1:0] settle
   );
      logic [COUNT_BITS-1:0] start;
      start = (level != fresh) ? settle : count;
      return (start == '0) ? start : start - COUNT_BITS'(1);
   endfunction

   function automatic alarm_type classify(
      input logic [LEVEL_BITS-1:0] a,
      input logic [LEVEL_BITS-1:0] b
   );
      alarm_type result;
      result = ALARM_UNKNOWN;
      case (a)
         3'd1: begin
            if (b == 3'd0) result = ALARM_NORMAL;
            else if (b == 3'd2) result = ALARM_TROUBLE;
         end
         3'd3: begin
            if (b == 3'd0) result = ALARM_INTRUSION;
            else if (b == 3'd2) result = ALARM_MASK;
         end
         3'd5: begin
            if (b == 3'd0) result = ALARM_TAMPER;
         end
         default: result = ALARM_UNKNOWN;
      endcase
      return result;
   endfunction

endpackage

// ----- sv/almon_quant.sv -----
module almon_quant #(
   parameter int NUM_THR     = almon_pkg::NUM_THR_ONE,
   parameter int SAMPLE_BITS = almon_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic [NUM_THR*almon_pkg::THR_BITS-1:0] thresholds,
   input  logic [SAMPLE_BITS-1:0]                 sample,
   output logic [almon_pkg::LEVEL_BITS-1:0]       level
);
   import almon_pkg::*;

   localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

   logic [CMP_BITS-1:0] sample_ext;

   assign sample_ext = CMP_BITS'(sample);

   // first threshold the sample is strictly below wins
   always_comb begin
      level = LEVEL_BITS'(NUM_THR);
      for (int i = NUM_THR - 1; i >= 0; i--) begin
         if (sample_ext < CMP_BITS'(thresholds[i*THR_BITS +: THR_BITS])) begin
            level = LEVEL_BITS'(i);
         end
      end
   end

endmodule

// ----- sv/almon_csr.sv -----
module almon_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [almon_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [almon_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output almon_pkg::cfg_type                   cfg,
   output almon_pkg::en_event_type              en_event
);
   import almon_pkg::*;

   logic [THR_ONE_BITS-1:0] thr_one_ff, thr_one_in;
   logic [THR_TWO_BITS-1:0] thr_two_ff, thr_two_in;
   logic [COUNT_BITS-1:0]   settle_ff, settle_in;
   logic                    enable_ff, enable_in;

   always_comb begin
      thr_one_in = thr_one_ff;
      thr_two_in = thr_two_ff;
      settle_in  = settle_ff;
      enable_in  = enable_ff;
      if (csr_wr_en) begin
         case (csr_type'(csr_index))
            CSR_THR_ONE: thr_one_in = csr_wdata[THR_ONE_BITS-1:0];
            CSR_THR_TWO: thr_two_in = csr_wdata[THR_TWO_BITS-1:0];
            CSR_SETTLE:  settle_in  = csr_wdata[COUNT_BITS-1:0];
            CSR_ENABLE:  enable_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_one_ff <= '0;
         thr_two_ff <= '0;
         settle_ff  <= SETTLE_RESET;
         enable_ff  <= 1'b1;
      end else begin
         thr_one_ff <= thr_one_in;
         thr_two_ff <= thr_two_in;
         settle_ff  <= settle_in;
         enable_ff  <= enable_in;
      end
   end

   assign cfg.thr_one = thr_one_ff;
   assign cfg.thr_two = thr_two_ff;
   assign cfg.settle  = settle_ff;
   assign cfg.enable  = enable_ff;

   assign en_event.change = (enable_in != enable_ff);
   assign en_event.value  = enable_in;

endmodule

// ----- sv/almon_state.sv -----
module almon_state (
   input  logic                    clock,
   input  logic                    reset,
   input  almon_pkg::cmd_type      cmd,
   input  almon_pkg::cfg_type      cfg,
   input  almon_pkg::en_event_type en_event,
   output almon_pkg::status_type   status_in
);
   import almon_pkg::*;

   logic [LEVEL_BITS-1:0] level_one_ff, level_one_in;
   logic [LEVEL_BITS-1:0] level_two_ff, level_two_in;
   logic [COUNT_BITS-1:0] count_one_ff, count_one_in;
   logic [COUNT_BITS-1:0] count_two_ff, count_two_in;
   alarm_type             alarm_ff, alarm_in;

   always_comb begin
      level_one_in = level_one_ff;
      level_two_in = level_two_ff;
      count_one_in = count_one_ff;
      count_two_in = count_two_ff;
      alarm_in     = alarm_ff;
      if (cmd.fire && cfg.enable) begin
         case (op_type'(cmd.op))
            OP_LOOP_ONE: begin
               level_one_in = cmd.level_one_new;
               count_one_in = debounce_count(level_one_ff, cmd.level_one_new,
                                             count_one_ff, cfg.settle);
            end
            OP_LOOP_TWO: begin
               level_two_in = cmd.level_two_new;
               count_two_in = debounce_count(level_two_ff, cmd.level_two_new,
                                             count_two_ff, cfg.settle);
            end
            OP_EVALUATE: begin
               if (count_one_ff == '0 && count_two_ff == '0) begin
                  alarm_in = classify(level_one_ff, level_two_ff);
               end
            end
            default: ;
         endcase
      end
      if (en_event.change) begin
         alarm_in = en_event.value ? ALARM_UNKNOWN : ALARM_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_one_ff <= '0;
         level_two_ff <= '0;
         count_one_ff <= SETTLE_RESET;
         count_two_ff <= SETTLE_RESET;
         alarm_ff     <= ALARM_UNKNOWN;
      end else begin
         level_one_ff <= level_one_in;
         level_two_ff <= level_two_in;
         count_one_ff <= count_one_in;
         count_two_ff <= count_two_in;
         alarm_ff     <= alarm_in;
      end
   end

   assign status_in.alarm     = alarm_in;
   assign status_in.level_one = level_one_in;
   assign status_in.level_two = level_two_in;
   assign status_in.settled   = (count_one_in == '0) && (count_two_in == '0);

endmodule

// ----- sv/alarm_loop_level_monitor_core.sv -----
// channel | direction | handshake               | payload
// req     | in        | req_valid / req_stall   | req_op, req_sample
// rsp     | out       | rsp_valid / rsp_stall   | rsp_alarm_state, rsp_loop_one_level,
//         |           |                         | rsp_loop_two_level, rsp_settled
// csr     | in        | csr_wr_en               | csr_index, csr_wdata
//
// One transaction per cycle sustained unless the result stalls; an accepted transaction
// waits in the input register, then loads the result register and sets rsp_valid.
// The threshold compares, debounce and alarm map sit between the input and result registers.
// Synchronous reset clears both valid stages and levels, reloads counters and CSR registers.
// A stalled result holds the result register; the input register still takes one more
// transaction, and req_stall rises only when both registers are full.
module alarm_loop_level_monitor_core #(
   parameter int SAMPLE_BITS = almon_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [almon_pkg::OP_BITS-1:0]        req_op,
   input  logic [SAMPLE_BITS-1:0]               req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [almon_pkg::ALARM_BITS-1:0]     rsp_alarm_state,
   output logic [almon_pkg::LEVEL_BITS-1:0]     rsp_loop_one_level,
   output logic [almon_pkg::LEVEL_BITS-1:0]     rsp_loop_two_level,
   output logic                                 rsp_settled,
   input  logic                                 csr_wr_en,
   input  logic [almon_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [almon_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import almon_pkg::*;

   logic                   s1_valid_ff, s1_valid_in;
   logic [OP_BITS-1:0]     s1_op_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff;

   logic                   accept;
   logic                   advance;
   logic [LEVEL_BITS-1:0]  level_one_new;
   logic [LEVEL_BITS-1:0]  level_two_new;
   cfg_type                cfg;
   en_event_type           en_event;
   cmd_type                cmd;
   status_type             status_in;

   almon_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .en_event  (en_event)
   );

   almon_quant #(
      .NUM_THR     (NUM_THR_ONE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_quant_one (
      .thresholds (cfg.thr_one),
      .sample     (s1_sample_ff),
      .level      (level_one_new)
   );

   almon_quant #(
      .NUM_THR     (NUM_THR_TWO),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_quant_two (
      .thresholds (cfg.thr_two),
      .sample     (s1_sample_ff),
      .level      (level_two_new)
   );

   assign cmd.fire          = advance;
   assign cmd.op            = s1_op_ff;
   assign cmd.level_one_new = level_one_new;
   assign cmd.level_two_new = level_two_new;

   almon_state u_state (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .en_event  (en_event),
      .status_in (status_in)
   );

   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff     <= req_op;
         s1_sample_ff <= req_sample;
      end
      if (advance) begin
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alarm_state    = rsp_status_ff.alarm;
   assign rsp_loop_one_level = rsp_status_ff.level_one;
   assign rsp_loop_two_level = rsp_status_ff.level_two;
   assign rsp_settled        = rsp_status_ff.settled;

endmodule

// ----- sv/almon_checker.sv -----
module almon_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [almon_pkg::ALARM_BITS-1:0] rsp_alarm_state,
   input logic [almon_pkg::LEVEL_BITS-1:0] rsp_loop_one_level,
   input logic [almon_pkg::LEVEL_BITS-1:0] rsp_loop_two_level,
   input logic                             rsp_settled
);
   import almon_pkg::*;

   // hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_alarm_state)
         && $stable(rsp_loop_one_level) && $stable(rsp_loop_two_level)
         && $stable(rsp_settled))
      else $error("stalled result transaction changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_loop_one_level <= LEVEL_ONE_MAX
         && rsp_loop_two_level <= LEVEL_TWO_MAX)
      else $error("loop level out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alarm_state <= ALARM_UNKNOWN)
      else $error("alarm state out of range");

   // drop nothing through reset: no result right after it
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a new result needs an earlier request valid or a request stall before it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid, 2) || $past(req_stall, 1))
      else $error("result without an earlier request transaction");

endmodule

bind alarm_loop_level_monitor_core almon_checker u_almon_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_alarm_state    (rsp_alarm_state),
   .rsp_loop_one_level (rsp_loop_one_level),
   .rsp_loop_two_level (rsp_loop_two_level),
   .rsp_settled        (rsp_settled)
);

// ----- bench/alarm_loop_level_monitor_checker.sv -----
module alarm_loop_level_monitor_checker
   import almon_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [OP_BITS-1:0]        req_op,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [ALARM_BITS-1:0]     rsp_alarm_state,
   input  logic [LEVEL_BITS-1:0]     rsp_loop_one_level,
   input  logic [LEVEL_BITS-1:0]     rsp_loop_two_level,
   input  logic                      rsp_settled,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        errors,
   output int                        pending,
   output int                        checked
);

   logic [THR_ONE_BITS-1:0] thr_one;
   logic [THR_TWO_BITS-1:0] thr_two;
   logic [COUNT_BITS-1:0]   settle;
   logic                    enable;

   logic [LEVEL_BITS-1:0]   lvl_one;
   logic [LEVEL_BITS-1:0]   lvl_two;
   logic [COUNT_BITS-1:0]   cnt_one;
   logic [COUNT_BITS-1:0]   cnt_two;
   alarm_type               alarm;

   status_type              expected_status[$];

   function automatic logic [LEVEL_BITS-1:0] level_of(
      input logic [THR_ONE_BITS-1:0] thr,
      input int                      num,
      input logic [SAMPLE_BITS-1:0]  s
   );
      logic [LEVEL_BITS-1:0] lvl;
      int                    i;
      lvl = LEVEL_BITS'(num);
      // scan downward so the lowest-indexed threshold above the sample wins
      for (i = num - 1; i >= 0; i--) begin
         if (s < thr[i*THR_BITS +: THR_BITS]) lvl = LEVEL_BITS'(i);
      end
      return lvl;
   endfunction

   function automatic logic [COUNT_BITS-1:0] next_count(
      input logic [LEVEL_BITS-1:0] lvl,
      input logic [LEVEL_BITS-1:0] fresh,
      input logic [COUNT_BITS-1:0] cnt
   );
      logic [COUNT_BITS-1:0] c;
      c = (lvl != fresh) ? settle : cnt;
      if (c != '0) c = c - COUNT_BITS'(1);
      return c;
   endfunction

   function automatic alarm_type alarm_for(
      input logic [LEVEL_BITS-1:0] a,
      input logic [LEVEL_BITS-1:0] b
   );
      alarm_type r;
      case ({a, b})
         {3'd1, 3'd0}: r = ALARM_NORMAL;
         {3'd1, 3'd2}: r = ALARM_TROUBLE;
         {3'd3, 3'd0}: r = ALARM_INTRUSION;
         {3'd3, 3'd2}: r = ALARM_MASK;
         {3'd5, 3'd0}: r = ALARM_TAMPER;
         default:      r = ALARM_UNKNOWN;
      endcase
      return r;
   endfunction

   task automatic write_register(input csr_type idx, input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_THR_ONE: thr_one = data[THR_ONE_BITS-1:0];
         CSR_THR_TWO: thr_two = data[THR_TWO_BITS-1:0];
         CSR_SETTLE:  settle = data[COUNT_BITS-1:0];
         CSR_ENABLE: begin
            if (data[0] != enable) begin
               enable = data[0];
               alarm = data[0] ? ALARM_UNKNOWN : ALARM_NORMAL;
            end
         end
         default: ;
      endcase
   endtask

   task automatic predict_status(input logic [OP_BITS-1:0] op, input logic [SAMPLE_BITS-1:0] s);
      logic [LEVEL_BITS-1:0] fresh;
      status_type            st;
      if (enable) begin
         case (op)
            OP_LOOP_ONE: begin
               fresh = level_of(thr_one, NUM_THR_ONE, s);
               cnt_one = next_count(lvl_one, fresh, cnt_one);
               lvl_one = fresh;
            end
            OP_LOOP_TWO: begin
               fresh = level_of(THR_ONE_BITS'(thr_two), NUM_THR_TWO, s);
               cnt_two = next_count(lvl_two, fresh, cnt_two);
               lvl_two = fresh;
            end
            OP_EVALUATE: begin
               if (cnt_one == '0 && cnt_two == '0) alarm = alarm_for(lvl_one, lvl_two);
            end
            default: ;
         endcase
      end
      st.alarm = alarm;
      st.level_one = lvl_one;
      st.level_two = lvl_two;
      st.settled = (cnt_one == '0 && cnt_two == '0);
      expected_status.push_back(st);
   endtask

   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      status_type want;
      if (reset) begin
         thr_one = '0;
         thr_two = '0;
         settle = SETTLE_RESET;
         enable = 1'b1;
         lvl_one = '0;
         lvl_two = '0;
         cnt_one = SETTLE_RESET;
         cnt_two = SETTLE_RESET;
         alarm = ALARM_UNKNOWN;
         expected_status.delete();
         errors = 0;
         checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               errors++;
               $display("%0t: response with no transaction outstanding", $time);
            end else begin
               want = expected_status.pop_front();
               checked++;
               compare_field("alarm_state", 8'(want.alarm), 8'(rsp_alarm_state));
               compare_field("loop_one_level", 8'(want.level_one), 8'(rsp_loop_one_level));
               compare_field("loop_two_level", 8'(want.level_two), 8'(rsp_loop_two_level));
               compare_field("settled", 8'(want.settled), 8'(rsp_settled));
            end
         end
         if (csr_wr_en) write_register(csr_type'(csr_index), csr_wdata);
         if (req_valid && !req_stall) predict_status(req_op, req_sample);
      end
      pending = expected_status.size();
   end

endmodule

// ----- bench/alarm_loop_level_monitor_core_tb.sv -----
module alarm_loop_level_monitor_core_tb;
   import almon_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 60;
   localparam int SAMPLE_MAX = (1 << SAMPLE_BITS_DEFAULT) - 1;
   localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [OP_BITS-1:0]             req_op;
   logic [SAMPLE_BITS_DEFAULT-1:0] req_sample;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [ALARM_BITS-1:0]          rsp_alarm_state;
   logic [LEVEL_BITS-1:0]          rsp_loop_one_level;
   logic [LEVEL_BITS-1:0]          rsp_loop_two_level;
   logic                           rsp_settled;
   logic                           csr_wr_en;
   logic [CSR_INDEX_BITS-1:0]      csr_index;
   logic [CSR_DATA_BITS-1:0]       csr_wdata;

   int errors;
   int pending;
   int checked;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int sent_items = 0;

   logic [THR_ONE_BITS-1:0] cur_one;
   logic [THR_TWO_BITS-1:0] cur_two;
   logic [COUNT_BITS-1:0]   cur_settle;

   alarm_loop_level_monitor_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_alarm_state    (rsp_alarm_state),
      .rsp_loop_one_level (rsp_loop_one_level),
      .rsp_loop_two_level (rsp_loop_two_level),
      .rsp_settled        (rsp_settled),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   alarm_loop_level_monitor_checker status_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_alarm_state    (rsp_alarm_state),
      .rsp_loop_one_level (rsp_loop_one_level),
      .rsp_loop_two_level (rsp_loop_two_level),
      .rsp_settled        (rsp_settled),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .errors             (errors),
      .pending            (pending),
      .checked            (checked)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send(input logic [OP_BITS-1:0] op, input int s);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_sample <= SAMPLE_BITS_DEFAULT'(s);
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic put_reg(input csr_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(
      input logic [THR_ONE_BITS-1:0] thr1,
      input logic [THR_TWO_BITS-1:0] thr2,
      input logic [COUNT_BITS-1:0]   settle,
      input logic                    en
   );
      cur_one = thr1;
      cur_two = thr2;
      cur_settle = settle;
      drain();
      put_reg(CSR_THR_ONE, CSR_DATA_BITS'(thr1));
      put_reg(CSR_THR_TWO, CSR_DATA_BITS'(thr2));
      put_reg(CSR_SETTLE, CSR_DATA_BITS'(settle));
      put_reg(CSR_ENABLE, CSR_DATA_BITS'(en));
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [THR_ONE_BITS-1:0] ascending(input int num);
      logic [THR_ONE_BITS-1:0] v;
      int                      t;
      int                      i;
      v = '0;
      t = 0;
      for (i = 0; i < num; i++) begin
         t += $urandom_range(SAMPLE_MAX / (num + 1), 1);
         v[i*THR_BITS +: THR_BITS] = THR_BITS'(t);
      end
      return v;
   endfunction

   // pick a reading inside the band of level k, or anywhere if the band is empty
   function automatic int band_sample(input logic [THR_ONE_BITS-1:0] thr, input int num, input int k);
      int lo;
      int hi;
      lo = (k == 0) ? 0 : int'(thr[(k-1)*THR_BITS +: THR_BITS]);
      hi = (k == num) ? SAMPLE_MAX + 1 : int'(thr[k*THR_BITS +: THR_BITS]);
      if (lo < hi) return $urandom_range(hi - 1, lo);
      return $urandom_range(SAMPLE_MAX, 0);
   endfunction

   task automatic drive_pair(input int k1, input int k2);
      int runs;
      runs = (cur_settle > 5) ? $urandom_range(6, 1) : int'(cur_settle) + $urandom_range(1, 0);
      if (runs == 0) runs = 1;
      repeat (runs) begin
         send(OP_LOOP_ONE, band_sample(cur_one, NUM_THR_ONE, k1));
         send(OP_LOOP_TWO, band_sample(THR_ONE_BITS'(cur_two), NUM_THR_TWO, k2));
      end
      send(OP_EVALUATE, $urandom_range(SAMPLE_MAX, 0));
   endtask

   initial begin : stimulus
      int                      p;
      int                      pick;
      int                      start;
      logic [THR_ONE_BITS-1:0] t1;
      logic [THR_TWO_BITS-1:0] t2;
      logic [COUNT_BITS-1:0]   st;

      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_LOOP_ONE;
      req_sample = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_THR_ONE;
      csr_wdata = '0;
      cur_one = '0;
      cur_two = '0;
      cur_settle = SETTLE_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero thresholds, loops unsettled
      send(OP_LOOP_ONE, SAMPLE_MAX);
      send(OP_EVALUATE, 0);
      send(OP_SPARE, SAMPLE_MAX);

      configure({12'd2500, 12'd2000, 12'd1500, 12'd1000, 12'd500},
                {12'd2400, 12'd1800, 12'd1200, 12'd600}, 8'd1, 1'b1);
      send(OP_LOOP_ONE, 0);
      send(OP_LOOP_ONE, SAMPLE_MAX);
      send(OP_LOOP_TWO, 2000);
      send(OP_LOOP_TWO, 0);
      send(OP_EVALUATE, 0);
      send(OP_LOOP_ONE, 700);
      send(OP_EVALUATE, SAMPLE_MAX);
      send(OP_LOOP_TWO, 1500);
      send(OP_EVALUATE, 0);
      send(OP_LOOP_ONE, 1700);
      send(OP_EVALUATE, 0);
      send(OP_LOOP_TWO, 599);
      send(OP_EVALUATE, 0);
      send(OP_LOOP_TWO, SAMPLE_MAX);
      send(OP_EVALUATE, 0);
      send(OP_LOOP_ONE, 499);

      configure(cur_one, cur_two, 8'd1, 1'b0);
      send(OP_LOOP_ONE, SAMPLE_MAX);
      send(OP_EVALUATE, 0);
      send(OP_LOOP_TWO, 0);
      configure(cur_one, cur_two, 8'd1, 1'b1);
      send(OP_EVALUATE, 0);

      for (p = 0; p < PHASES; p++) begin
         case (p)
            3: begin
               t1 = THR_ONE_BITS'({$urandom, $urandom});
               t2 = THR_TWO_BITS'({$urandom, $urandom});
            end
            4: begin
               t1 = '1;
               t2 = '1;
            end
            7: begin
               t1 = '0;
               t2 = '0;
            end
            default: begin
               t1 = ascending(NUM_THR_ONE);
               t2 = THR_TWO_BITS'(ascending(NUM_THR_TWO));
            end
         endcase
         case (p)
            0: st = 8'd2;
            1: st = 8'd0;
            2: st = 8'd3;
            3: st = 8'd1;
            4: st = 8'hFF;
            6: st = 8'd4;
            default: st = COUNT_BITS'($urandom_range(3, 1));
         endcase
         configure(t1, t2, st, p != 5);
         case (p % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 82;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 82;
            end
            default: begin
               idle_pct = 9;
               stall_pct = 9;
            end
         endcase
         start = sent_items;
         while (sent_items - start < PHASE_ITEMS) begin
            if ($urandom_range(99, 0) < 20) begin
               send(OP_BITS'($urandom_range(3, 0)), $urandom_range(SAMPLE_MAX, 0));
            end else begin
               pick = $urandom_range(5, 0);
               if (pick == 5) drive_pair($urandom_range(5, 0), $urandom_range(4, 0));
               else drive_pair((pick < 2) ? 1 : (pick < 4) ? 3 : 5, (pick % 2 == 1) ? 2 : 0);
            end
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("Run drove %0d requests: directed level and alarm cases, then %0d register settings",
               sent_items, PHASES);
      $display("with sender gaps and receiver stalls; %0d responses compared", checked);
      if (errors == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
